/* hw/rtl/tvtc_pkg.sv */
package tvtc_pkg;

   localparam int COEF_W   = 16;
   localparam int POS_W    = 16;
   localparam int COLOUR_W = 24;
   localparam int ROW_W    = 4 * COEF_W;
   localparam int CAM_W    = POS_W + 6;
   localparam int EDGE_W   = CAM_W + 1;
   localparam int CROSS_W  = 2 * EDGE_W;
   localparam int CLIP_W   = 32;

   typedef enum logic [2:0] {
      CSR_VIEW_ROW0  = 3'd0,
      CSR_VIEW_ROW1  = 3'd1,
      CSR_VIEW_ROW2  = 3'd2,
      CSR_PROJ_ROW0  = 3'd3,
      CSR_PROJ_ROW1  = 3'd4,
      CSR_PROJ_ROW2  = 3'd5,
      CSR_PROJ_ROW3  = 3'd6,
      CSR_NEAR_PLANE = 3'd7
   } csr_index_type;

   typedef logic signed [CAM_W-1:0] cam_type;

endpackage

/* hw/rtl/tvtc_dot.sv */
module tvtc_dot import tvtc_pkg::*; #(
   parameter int VecWidth = 16
) (
   input  logic                         clock,
   input  logic [ROW_W-1:0]             row,
   input  logic signed [VecWidth-1:0]   vec_x,
   input  logic signed [VecWidth-1:0]   vec_y,
   input  logic signed [VecWidth-1:0]   vec_z,
   output logic signed [VecWidth+5:0]   dot_ff
);

   localparam int ProdW = VecWidth + COEF_W;
   localparam int SumW  = VecWidth + COEF_W + 2;

   logic signed [COEF_W-1:0] coef0, coef1, coef2, coef3;
   logic signed [ProdW-1:0]  prod0_ff, prod1_ff, prod2_ff, prod0_in, prod1_in, prod2_in;
   logic signed [COEF_W+7:0] bias_ff, bias_in;
   logic signed [SumW-1:0]   sum;
   logic signed [VecWidth+5:0] dot_in;

   assign coef0 = $signed(row[0*COEF_W +: COEF_W]);
   assign coef1 = $signed(row[1*COEF_W +: COEF_W]);
   assign coef2 = $signed(row[2*COEF_W +: COEF_W]);
   assign coef3 = $signed(row[3*COEF_W +: COEF_W]);

   assign prod0_in = ProdW'(coef0) * ProdW'(vec_x);
   assign prod1_in = ProdW'(coef1) * ProdW'(vec_y);
   assign prod2_in = ProdW'(coef2) * ProdW'(vec_z);
   assign bias_in  = {coef3, 8'd0};

   // Round half up: add half an LSB, then an arithmetic shift floors.
   assign sum = SumW'(prod0_ff) + SumW'(prod1_ff) + SumW'(prod2_ff) + SumW'(bias_ff)
              + SumW'(2048);
   assign dot_in = sum[SumW-1:12];

   always_ff @(posedge clock) begin
      prod0_ff <= prod0_in;
      prod1_ff <= prod1_in;
      prod2_ff <= prod2_in;
      bias_ff  <= bias_in;
      dot_ff   <= dot_in;
   end

endmodule

/* hw/rtl/triangle_vertex_transform_cull.sv */
// Triangle vertex transform with near rejection and back-face culling.
// A request (one triangle: three Q8.8 vertices and their colours) is taken
// on a clock edge where start is high and busy is low. After a request,
// busy is held high by a down-counter, so the next triangle is accepted only
// when a kept triangle's three results have room on the single result
// channel, where one projection unit handles one vertex a cycle.
// A kept triangle gives three results, vertices a, b, c, on consecutive cycles,
// each shown for one cycle with rsp_valid high; rsp_last_vertex marks c.
// Results pass view transform, culling, serializer and projection. A culled
// triangle gives no results. The receiver cannot stall; results are never held.
// Configuration registers are written through csr_wr_en/csr_index/csr_wdata
// and must only change while no triangle is in flight.
// A synchronous reset empties the pipeline and restores identity matrices
// and a near distance of 1.0.
module triangle_vertex_transform_cull import tvtc_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic signed [POS_W-1:0]     req_a_x,
   input  logic signed [POS_W-1:0]     req_a_y,
   input  logic signed [POS_W-1:0]     req_a_z,
   input  logic signed [POS_W-1:0]     req_b_x,
   input  logic signed [POS_W-1:0]     req_b_y,
   input  logic signed [POS_W-1:0]     req_b_z,
   input  logic signed [POS_W-1:0]     req_c_x,
   input  logic signed [POS_W-1:0]     req_c_y,
   input  logic signed [POS_W-1:0]     req_c_z,
   input  logic [COLOUR_W-1:0]         req_a_colour,
   input  logic [COLOUR_W-1:0]         req_b_colour,
   input  logic [COLOUR_W-1:0]         req_c_colour,
   input  logic                        csr_wr_en,
   input  logic [2:0]                  csr_index,
   input  logic [ROW_W-1:0]            csr_wdata,
   output logic                        rsp_valid,
   output logic signed [CLIP_W-1:0]    rsp_clip_x,
   output logic signed [CLIP_W-1:0]    rsp_clip_y,
   output logic signed [CLIP_W-1:0]    rsp_clip_z,
   output logic signed [CLIP_W-1:0]    rsp_clip_w,
   output logic [COLOUR_W-1:0]         rsp_vertex_colour,
   output logic                        rsp_last_vertex
);

   logic [ROW_W-1:0] view_row_ff [3];
   logic [ROW_W-1:0] proj_row_ff [4];
   logic [15:0]      near_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_row_ff[0] <= ROW_W'(64'd4096);
         view_row_ff[1] <= ROW_W'(64'd4096 << 16);
         view_row_ff[2] <= ROW_W'(64'd4096 << 32);
         proj_row_ff[0] <= ROW_W'(64'd4096);
         proj_row_ff[1] <= ROW_W'(64'd4096 << 16);
         proj_row_ff[2] <= ROW_W'(64'd4096 << 32);
         proj_row_ff[3] <= ROW_W'(64'd4096 << 48);
         near_ff        <= 16'd256;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_VIEW_ROW0:  view_row_ff[0] <= csr_wdata;
            CSR_VIEW_ROW1:  view_row_ff[1] <= csr_wdata;
            CSR_VIEW_ROW2:  view_row_ff[2] <= csr_wdata;
            CSR_PROJ_ROW0:  proj_row_ff[0] <= csr_wdata;
            CSR_PROJ_ROW1:  proj_row_ff[1] <= csr_wdata;
            CSR_PROJ_ROW2:  proj_row_ff[2] <= csr_wdata;
            CSR_PROJ_ROW3:  proj_row_ff[3] <= csr_wdata;
            CSR_NEAR_PLANE: near_ff        <= csr_wdata[15:0];
            default:        near_ff        <= near_ff;
         endcase
      end
   end

   // Request pacing.
   logic       accept;
   logic [1:0] cnt_ff, cnt_in;

   assign busy   = (cnt_ff != 2'd0);
   assign accept = start && !busy;
   assign cnt_in = accept ? 2'd2 : (busy ? cnt_ff - 2'd1 : 2'd0);

   // Stage 1: captured triangle.
   logic signed [POS_W-1:0] s1_pos_ff [3][3];
   logic [COLOUR_W-1:0]     col_ff [1:5][3];
   logic [5:1]              vld_ff;

   // Stages 2 and 3: view transform inside the dot units.
   cam_type cam3 [3][3];

   for (genvar v = 0; v < 3; v++) begin : g_view_vtx
      for (genvar r = 0; r < 3; r++) begin : g_view_row
         tvtc_dot #(.VecWidth(POS_W)) u_view (
            .clock  (clock),
            .row    (view_row_ff[r]),
            .vec_x  (s1_pos_ff[v][0]),
            .vec_y  (s1_pos_ff[v][1]),
            .vec_z  (s1_pos_ff[v][2]),
            .dot_ff (cam3[v][r])
         );
      end
   end

   // Stage 4: near test and edges.
   logic signed [CAM_W:0]    neg_near;
   logic                     near_cull_in, near4_ff, near5_ff;
   logic signed [EDGE_W-1:0] e1x_ff, e1y_ff, e2x_ff, e2y_ff;
   logic signed [EDGE_W-1:0] e1x_in, e1y_in, e2x_in, e2y_in;
   cam_type                  cam4_ff [3][3];
   cam_type                  cam5_ff [3][3];

   assign neg_near = -$signed((CAM_W+1)'(near_ff));
   assign near_cull_in = ((CAM_W+1)'(cam3[0][2]) > neg_near)
                      && ((CAM_W+1)'(cam3[1][2]) > neg_near)
                      && ((CAM_W+1)'(cam3[2][2]) > neg_near);
   assign e1x_in = EDGE_W'(cam3[1][0]) - EDGE_W'(cam3[0][0]);
   assign e1y_in = EDGE_W'(cam3[1][1]) - EDGE_W'(cam3[0][1]);
   assign e2x_in = EDGE_W'(cam3[2][0]) - EDGE_W'(cam3[0][0]);
   assign e2y_in = EDGE_W'(cam3[2][1]) - EDGE_W'(cam3[0][1]);

   // Stage 5: the two products of the edge cross product.
   logic signed [CROSS_W-1:0] m1_ff, m2_ff, m1_in, m2_in;
   logic signed [CROSS_W:0]   cross_z;
   logic                      keep;

   assign m1_in   = CROSS_W'(e1x_ff) * CROSS_W'(e2y_ff);
   assign m2_in   = CROSS_W'(e1y_ff) * CROSS_W'(e2x_ff);
   assign cross_z = (CROSS_W+1)'(m1_ff) - (CROSS_W+1)'(m2_ff);
   assign keep    = vld_ff[5] && !near5_ff && (cross_z > 0);

   // Vertex serializer feeding the projection unit.
   cam_type             ser_cam_ff [3][3];
   logic [COLOUR_W-1:0] ser_col_ff [3];
   logic                ser_act_ff, ser_act_in;
   logic [1:0]          ser_idx_ff, ser_idx_in;

   always_comb begin
      ser_act_in = ser_act_ff;
      ser_idx_in = ser_idx_ff;
      if (keep) begin
         ser_act_in = 1'b1;
         ser_idx_in = 2'd0;
      end else if (ser_act_ff) begin
         ser_idx_in = ser_idx_ff + 2'd1;
         if (ser_idx_ff == 2'd2) begin
            ser_act_in = 1'b0;
         end
      end
   end

   logic signed [CAM_W+5:0] clip [4];

   for (genvar r = 0; r < 4; r++) begin : g_proj_row
      tvtc_dot #(.VecWidth(CAM_W)) u_proj (
         .clock  (clock),
         .row    (proj_row_ff[r]),
         .vec_x  (ser_cam_ff[ser_idx_ff][0]),
         .vec_y  (ser_cam_ff[ser_idx_ff][1]),
         .vec_z  (ser_cam_ff[ser_idx_ff][2]),
         .dot_ff (clip[r])
      );
   end

   logic [2:1]          pv_ff;
   logic [COLOUR_W-1:0] pcol_ff [2:1];
   logic [2:1]          plast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= 2'd0;
         vld_ff     <= '0;
         ser_act_ff <= 1'b0;
         ser_idx_ff <= 2'd0;
         pv_ff      <= '0;
      end else begin
         cnt_ff     <= cnt_in;
         vld_ff     <= {vld_ff[4:1], accept};
         ser_act_ff <= ser_act_in;
         ser_idx_ff <= ser_idx_in;
         pv_ff      <= {pv_ff[1], ser_act_ff};
      end
   end

   always_ff @(posedge clock) begin
      s1_pos_ff[0][0] <= req_a_x;
      s1_pos_ff[0][1] <= req_a_y;
      s1_pos_ff[0][2] <= req_a_z;
      s1_pos_ff[1][0] <= req_b_x;
      s1_pos_ff[1][1] <= req_b_y;
      s1_pos_ff[1][2] <= req_b_z;
      s1_pos_ff[2][0] <= req_c_x;
      s1_pos_ff[2][1] <= req_c_y;
      s1_pos_ff[2][2] <= req_c_z;
      col_ff[1][0] <= req_a_colour;
      col_ff[1][1] <= req_b_colour;
      col_ff[1][2] <= req_c_colour;
      for (int s = 2; s <= 5; s++) begin
         col_ff[s] <= col_ff[s-1];
      end
      cam4_ff  <= cam3;
      cam5_ff  <= cam4_ff;
      near4_ff <= near_cull_in;
      near5_ff <= near4_ff;
      e1x_ff   <= e1x_in;
      e1y_ff   <= e1y_in;
      e2x_ff   <= e2x_in;
      e2y_ff   <= e2y_in;
      m1_ff    <= m1_in;
      m2_ff    <= m2_in;
      if (keep) begin
         ser_cam_ff <= cam5_ff;
         ser_col_ff <= col_ff[5];
      end
      pcol_ff[1]  <= ser_col_ff[ser_idx_ff];
      pcol_ff[2]  <= pcol_ff[1];
      plast_ff[1] <= (ser_idx_ff == 2'd2);
      plast_ff[2] <= plast_ff[1];
   end

   // The projected values span 28 bits, so the 32-bit range is never exceeded.
   assign rsp_valid         = pv_ff[2];
   assign rsp_clip_x        = CLIP_W'(clip[0]);
   assign rsp_clip_y        = CLIP_W'(clip[1]);
   assign rsp_clip_z        = CLIP_W'(clip[2]);
   assign rsp_clip_w        = CLIP_W'(clip[3]);
   assign rsp_vertex_colour = pcol_ff[2];
   assign rsp_last_vertex   = plast_ff[2];

endmodule
